// File: src/smt_pkg.sv
// Shared types and constants for the sparse matrix transpose block
`timescale 1ns / 1ps

package smt_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_NONZERO_DEF = 64;

    localparam int ROW_W     = 7;
    localparam int COL_W     = 7;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

    // input item kinds
    localparam logic KIND_TERM = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [ROW_W-1:0]        orig_row;
        logic [COL_W-1:0]        orig_col;
        logic signed [VAL_W-1:0] term_value;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]        new_row;
        logic [ROW_W-1:0]        new_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
        logic                    dropped;
    } out_item_t;

    // one stored term; in the output store row/col are already swapped
    typedef struct packed {
        logic [6:0]              row;
        logic [6:0]              col;
        logic signed [VAL_W-1:0] value;
    } term_t;

    typedef struct packed {
        logic term_wr;       // write incoming term into the input store
        logic cnt_inc;       // finish column count increment
        logic cnt_clr;       // zero one count entry (reset sweep)
        logic pfx_init;      // clear running sum
        logic pfx_rd;        // prefix sum step for one column
        logic scat_wr;       // place one term into the output store
        logic emit_load;     // load output register
        logic emit_last;
        logic emit_dropped;
    } smt_cmd_t;

endpackage

// File: src/smt_datapath.sv
// Datapath: term, count, start position and output stores plus output register
`timescale 1ns / 1ps

module smt_datapath #(
    parameter int  MAX_COLUMNS = smt_pkg::MAX_COLUMNS_DEF,
    parameter int  MAX_NONZERO = smt_pkg::MAX_NONZERO_DEF,
    localparam int CIW   = $clog2(MAX_COLUMNS),
    localparam int NZ_AW = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  smt_pkg::in_item_t   in_data,
    input  smt_pkg::smt_cmd_t   cmd,
    input  logic [CIW-1:0]      cnt_addr,
    input  logic [NZ_AW-1:0]    term_addr,
    output smt_pkg::out_item_t  out_data
);
    import smt_pkg::*;

    localparam int NZ_CW = $clog2(MAX_NONZERO + 1);

    term_t            term_mem [MAX_NONZERO];
    term_t            term_rd_reg;
    term_t            out_mem [MAX_NONZERO];
    term_t            out_rd_reg;
    logic [NZ_CW-1:0] cnt_mem [MAX_COLUMNS];
    logic [NZ_CW-1:0] cnt_rd_reg;
    logic [CIW-1:0]   cnt_addr_reg;
    logic [NZ_CW-1:0] start_mem [MAX_COLUMNS];
    logic [NZ_CW-1:0] start_rd_reg;
    logic [NZ_CW-1:0] sum_reg;
    logic             pfx_reg;
    logic             clr_reg;
    out_item_t        out_reg;

    logic             cnt_we;
    logic [NZ_CW-1:0] cnt_wdata;
    logic [CIW-1:0]   scat_col;
    logic             start_we;
    logic [CIW-1:0]   start_waddr;
    logic [NZ_CW-1:0] start_wdata;

    assign cnt_we    = cmd.cnt_inc | pfx_reg | clr_reg;
    assign cnt_wdata = cmd.cnt_inc ? cnt_rd_reg + NZ_CW'(1) : '0;

    assign scat_col    = CIW'(term_rd_reg.col);
    assign start_we    = pfx_reg | cmd.scat_wr;
    assign start_waddr = pfx_reg ? cnt_addr_reg : scat_col;
    assign start_wdata = pfx_reg ? sum_reg : start_rd_reg + NZ_CW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.term_wr)
        begin
            term_mem[term_addr] <= '{row: in_data.orig_row, col: in_data.orig_col,
                                     value: in_data.term_value};
        end
        term_rd_reg <= term_mem[term_addr];
    end

    // counts are cleared as the prefix pass consumes them
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_addr_reg] <= cnt_wdata;
        end
        cnt_rd_reg   <= cnt_mem[cnt_addr];
        cnt_addr_reg <= cnt_addr;
    end

    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            start_mem[start_waddr] <= start_wdata;
        end
        start_rd_reg <= start_mem[scat_col];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pfx_init)
        begin
            sum_reg <= '0;
        end
        else if (pfx_reg)
        begin
            sum_reg <= sum_reg + cnt_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scat_wr)
        begin
            out_mem[start_rd_reg[NZ_AW-1:0]] <= '{row: term_rd_reg.col, col: term_rd_reg.row,
                                                  value: term_rd_reg.value};
        end
        out_rd_reg <= out_mem[term_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_reg <= '{new_row: out_rd_reg.row, new_col: out_rd_reg.col,
                         out_value: out_rd_reg.value, last: cmd.emit_last,
                         dropped: cmd.emit_dropped};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pfx_reg <= 1'b0;
            clr_reg <= 1'b0;
        end
        else
        begin
            pfx_reg <= cmd.pfx_rd;
            clr_reg <= cmd.cnt_clr;
        end
    end

    assign out_data = out_reg;

endmodule

// File: src/smt_ctrl.sv
// Controller: load, prefix, scatter and emit sequencing, fill count and drop flag
`timescale 1ns / 1ps

module smt_ctrl #(
    parameter int  MAX_COLUMNS = smt_pkg::MAX_COLUMNS_DEF,
    parameter int  MAX_NONZERO = smt_pkg::MAX_NONZERO_DEF,
    localparam int CIW   = $clog2(MAX_COLUMNS),
    localparam int NZ_AW = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_kind,
    input  logic [smt_pkg::COL_W-1:0]     in_col,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          cfg_we,
    input  logic [smt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [smt_pkg::CFG_W-1:0]     cfg_data,
    output smt_pkg::smt_cmd_t             cmd,
    output logic [CIW-1:0]                cnt_addr,
    output logic [NZ_AW-1:0]              term_addr
);
    import smt_pkg::*;

    localparam int NZ_CW   = $clog2(MAX_NONZERO + 1);
    localparam int CIDX_W  = $clog2(MAX_COLUMNS + 1);

    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_LOAD      = 4'd2;
    localparam logic [3:0] ST_PFX       = 4'd3;
    localparam logic [3:0] ST_SCAT_PRE  = 4'd4;
    localparam logic [3:0] ST_SCAT_A    = 4'd5;
    localparam logic [3:0] ST_SCAT_B    = 4'd6;
    localparam logic [3:0] ST_EMIT_RD   = 4'd7;
    localparam logic [3:0] ST_EMIT_LD   = 4'd8;
    localparam logic [3:0] ST_EMIT_WAIT = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [CIDX_W-1:0] idx_reg, idx_next;
    logic [NZ_CW-1:0]  term_idx_reg, term_idx_next;
    logic [NZ_CW-1:0]  loaded_count_reg, loaded_count_next;
    logic              drop_reg, drop_next;
    logic              out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]  num_cols_reg;

    logic              accept;
    logic              col_ok;
    logic              store_full;
    logic [NZ_CW-1:0]  term_idx_inc;
    logic              idx_done;

    assign accept       = in_valid && in_ready;
    assign col_ok       = ({1'b0, in_col} < num_cols_reg) &&
                          (32'(in_col) < 32'(MAX_COLUMNS));
    assign store_full   = (loaded_count_reg == NZ_CW'(MAX_NONZERO));
    assign term_idx_inc = term_idx_reg + NZ_CW'(1);
    assign idx_done     = (idx_reg == CIDX_W'(MAX_COLUMNS));

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        term_idx_next     = term_idx_reg;
        loaded_count_next = loaded_count_reg;
        drop_next         = drop_reg;
        out_valid_next    = out_valid_reg;
        cmd               = '0;
        cmd.emit_last     = (term_idx_inc == loaded_count_reg);
        cmd.emit_dropped  = drop_reg;
        cnt_addr          = idx_reg[CIW-1:0];
        term_addr         = term_idx_reg[NZ_AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // the final step issues no clear, so the last zero lands before loads
                if (idx_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_clr = 1'b1;
                    idx_next    = idx_reg + CIDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                cnt_addr  = CIW'(in_col);
                term_addr = loaded_count_reg[NZ_AW-1:0];
                if (accept)
                begin
                    if (in_kind == KIND_TERM)
                    begin
                        if (!store_full && col_ok)
                        begin
                            cmd.term_wr       = 1'b1;
                            loaded_count_next = loaded_count_reg + NZ_CW'(1);
                            state_next        = ST_LOAD;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else if (loaded_count_reg == '0)
                    begin
                        drop_next = 1'b0;
                    end
                    else
                    begin
                        cmd.pfx_init = 1'b1;
                        idx_next     = '0;
                        state_next   = ST_PFX;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.cnt_inc = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_PFX:
            begin
                if (idx_done)
                begin
                    term_idx_next = '0;
                    state_next    = ST_SCAT_PRE;
                end
                else
                begin
                    cmd.pfx_rd = 1'b1;
                    idx_next   = idx_reg + CIDX_W'(1);
                end
            end
            ST_SCAT_PRE:
            begin
                state_next = ST_SCAT_A;
            end
            ST_SCAT_A:
            begin
                state_next = ST_SCAT_B;
            end
            ST_SCAT_B:
            begin
                cmd.scat_wr = 1'b1;
                term_addr   = term_idx_inc[NZ_AW-1:0];
                if (term_idx_inc == loaded_count_reg)
                begin
                    term_idx_next = '0;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    term_idx_next = term_idx_inc;
                    state_next    = ST_SCAT_A;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                cmd.emit_load  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (term_idx_inc == loaded_count_reg)
                    begin
                        loaded_count_next = '0;
                        drop_next         = 1'b0;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        term_idx_next = term_idx_inc;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            idx_reg          <= '0;
            term_idx_reg     <= '0;
            loaded_count_reg <= '0;
            drop_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            term_idx_reg     <= term_idx_next;
            loaded_count_reg <= loaded_count_next;
            drop_reg         <= drop_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= CFG_W'(128);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_NUM_COLS: num_cols_reg <= cfg_data;
                // row count only describes the result shape; nothing held
                REG_NUM_ROWS: ;
                default: ;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: src/sparse_matrix_transpose.sv
// Top level of the sparse matrix transpose block
// Usage: feed terms on the input channel (kind = term) as (row, col, value), one
// transfer each, then one end item (kind = end). The block then returns every
// kept term with row and column swapped, in column-major order of the source,
// load order kept within a column; last marks the final one and dropped is set
// on every result when any term was refused (store full or column at or past
// the column limit). An end item with no kept terms returns nothing.
// Sequence: a kept term goes through a load state (count read-modify-write on
// the count memory port); a refused term and an end item with no kept terms are
// taken in idle. Otherwise an end item runs a prefix pass over the count memory,
// then the scatter (input store read, then start position read and write for
// each kept term), then for each result an output store read, an output
// register load and any receiver stall. Input ready is low from the end item
// until the last result has been transferred.
// Reset: a sweep zeroes the count memory with input ready held low;
// configuration writes are taken throughout. A stalled result holds in the
// output register until transferred.
`timescale 1ns / 1ps

module sparse_matrix_transpose #(
    parameter int MAX_COLUMNS = smt_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_NONZERO = smt_pkg::MAX_NONZERO_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  smt_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output smt_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [smt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [smt_pkg::CFG_W-1:0]     cfg_data
);
    import smt_pkg::*;

    localparam int CIW   = $clog2(MAX_COLUMNS);
    localparam int NZ_AW = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;

    smt_cmd_t         cmd;
    logic [CIW-1:0]   cnt_addr;
    logic [NZ_AW-1:0] term_addr;

    smt_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_NONZERO (MAX_NONZERO)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_kind   (in_data.kind),
        .in_col    (in_data.orig_col),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cnt_addr  (cnt_addr),
        .term_addr (term_addr)
    );

    smt_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_NONZERO (MAX_NONZERO)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .cnt_addr  (cnt_addr),
        .term_addr (term_addr),
        .out_data  (out_data)
    );

    // no new input while a result is pending
    a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a result is pending");

    a_back_to_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last) |=> in_ready)
        else $error("block not idle after last result");

    a_load_then_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.term_wr |=> (cmd.cnt_inc && !in_ready))
        else $error("kept term not followed by count update");

    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.term_wr, cmd.cnt_inc, cmd.scat_wr, cmd.emit_load, cmd.pfx_rd}))
        else $error("overlapping datapath commands");

endmodule

// File: bench/smt_transpose_checker.sv
// Checker for the sparse matrix transpose: mirrors the block, predicts results, compares them
`timescale 1ns / 1ps

module smt_transpose_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  smt_pkg::in_item_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  smt_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [smt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [smt_pkg::CFG_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            results_checked,
    output int                            refused_terms,
    output int                            matrices_ended
);

    import smt_pkg::*;

    localparam int PRINT_CAP = 40;

    logic [CFG_W-1:0] cols_reg;
    term_t            loaded_terms [MAX_NONZERO_DEF];
    int               n_loaded;
    logic             any_dropped;
    out_item_t        transposed_q [$];
    int               fails;
    int               checked;
    int               refused;
    int               ended;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fails < PRINT_CAP)
        begin
            $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
        end
        fails++;
    endtask

    function automatic int column_limit();
        return (int'(cols_reg) < MAX_COLUMNS_DEF) ? int'(cols_reg) : MAX_COLUMNS_DEF;
    endfunction

    task automatic take_term(input in_item_t it);
        if (n_loaded >= MAX_NONZERO_DEF || int'(it.orig_col) >= column_limit())
        begin
            any_dropped = 1'b1;
            refused++;
        end
        else
        begin
            loaded_terms[n_loaded].row   = it.orig_row;
            loaded_terms[n_loaded].col   = it.orig_col;
            loaded_terms[n_loaded].value = it.term_value;
            n_loaded++;
        end
    endtask

    // column-major walk; scanning in load order keeps order within a column
    task automatic transpose_matrix();
        out_item_t r;
        int        placed;
        placed = 0;
        for (int c = 0; c < MAX_COLUMNS_DEF; c++)
        begin
            for (int i = 0; i < n_loaded; i++)
            begin
                if (int'(loaded_terms[i].col) == c)
                begin
                    placed++;
                    r.new_row   = loaded_terms[i].col;
                    r.new_col   = loaded_terms[i].row;
                    r.out_value = loaded_terms[i].value;
                    r.last      = (placed == n_loaded);
                    r.dropped   = any_dropped;
                    transposed_q.push_back(r);
                end
            end
        end
        n_loaded    = 0;
        any_dropped = 1'b0;
        ended++;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (transposed_q.size() == 0)
        begin
            report_mismatch("result with nothing expected, value", got.out_value, '0);
        end
        else
        begin
            want = transposed_q.pop_front();
            if (got.new_row !== want.new_row)
                report_mismatch("new_row", 32'(got.new_row), 32'(want.new_row));
            if (got.new_col !== want.new_col)
                report_mismatch("new_col", 32'(got.new_col), 32'(want.new_col));
            if (got.out_value !== want.out_value)
                report_mismatch("out_value", got.out_value, want.out_value);
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
            if (got.dropped !== want.dropped)
                report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
        end
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    = 8'd128;
            n_loaded    = 0;
            any_dropped = 1'b0;
            transposed_q.delete();
            fails       = 0;
            checked     = 0;
            refused     = 0;
            ended       = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            // a transfer sees the column limit held before this edge's write
            if (in_valid && in_ready)
            begin
                if (in_data.kind == KIND_TERM)
                    take_term(in_data);
                else
                    transpose_matrix();
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    // row count only describes the result shape
                    REG_NUM_ROWS: ;
                    REG_NUM_COLS: cols_reg = cfg_data;
                    default: ;
                endcase
            end
        end
        fail_count      <= fails;
        pending         <= transposed_q.size();
        results_checked <= checked;
        refused_terms   <= refused;
        matrices_ended  <= ended;
    end

endmodule

// File: bench/sparse_matrix_transpose_tb.sv
// Testbench top for the sparse matrix transpose: stimulus, flow control and verdict
`timescale 1ns / 1ps

module sparse_matrix_transpose_tb;

    import smt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = MAX_COLUMNS_DEF + 16;
    localparam int RANDOM_ITEMS = 21;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   results_checked;
    int   refused_terms;
    int   matrices_ended;
    int   cycle_count    = 0;
    int   items_sent     = 0;
    int   reg_writes     = 0;
    int   burst_left     = 0;
    int   cur_cols       = 128;
    logic hold_armed     = 1'b0;
    logic long_hold_done = 1'b0;

    sparse_matrix_transpose u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    smt_transpose_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .refused_terms   (refused_terms),
        .matrices_ended  (matrices_ended)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: runs of always-ready, coin-toss and stalled cycles, plus one long hold
    initial
    begin
        int run;
        int mode;
        forever
        begin
            if (hold_armed && !long_hold_done && out_valid)
            begin
                out_ready <= 1'b0;
                for (int held = 0; held < LONG_HOLD; held++)
                    @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                run  = $urandom_range(1, 24);
                repeat (run)
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        default: out_ready <= 1'b0;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // sender works in bursts; valid drops at a burst boundary (and in drain_to_idle)
    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_term(input int row, input int col, input logic [31:0] val);
        in_item_t it;
        it.kind       = KIND_TERM;
        it.orig_row   = row[ROW_W-1:0];
        it.orig_col   = col[COL_W-1:0];
        it.term_value = val;
        send_item(it);
    endtask

    task automatic send_end();
        in_item_t it;
        it.kind       = KIND_END;
        it.orig_row   = 7'($urandom);
        it.orig_col   = 7'($urandom);
        it.term_value = $urandom;
        send_item(it);
    endtask

    // settle time also covers the count clearing sweep after reset
    task automatic drain_to_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_shape(input int rows, input int cols);
        drain_to_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_NUM_ROWS;
        cfg_data <= rows[CFG_W-1:0];
        @(posedge clk);
        cfg_idx  <= REG_NUM_COLS;
        cfg_data <= cols[CFG_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_cols = cols;
        reg_writes += 2;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic int pick_column();
        int lim;
        lim = (cur_cols < MAX_COLUMNS_DEF) ? cur_cols : MAX_COLUMNS_DEF;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 127);
        return $urandom_range(0, lim - 1);
    endfunction

    initial
    begin
        int random_base;
        int n_terms;
        int cols;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // extremes of every field, shared columns keep load order
        set_shape(128, 128);
        send_term(0, 0, 32'h8000_0000);
        send_term(127, 127, 32'h7FFF_FFFF);
        send_term(5, 3, 32'hFFFF_FFFF);
        send_term(0, 3, 32'h0000_0001);
        send_term(127, 0, 32'h55AA_55AA);
        send_term(64, 3, 32'h0000_0000);
        send_end();
        // empty matrix
        send_end();
        // single term, last on the only result
        send_term(10, 127, 32'hAAAA_5555);
        send_end();
        // shape change between loads and the end transfer; earlier terms stay
        send_term(1, 100, 32'h1234_5678);
        send_term(2, 50, 32'h8765_4321);
        set_shape(128, 2);
        send_term(3, 1, 32'hDEAD_BEEF);
        send_term(4, 5, 32'hCAFE_F00D);
        send_end();
        // drop flag must not carry over
        send_term(0, 0, 32'h0BAD_F00D);
        send_end();
        // zero columns refuses everything
        set_shape(1, 0);
        send_term(127, 0, 32'h7777_7777);
        send_end();
        // row beyond num_rows is kept
        set_shape(1, 1);
        send_term(100, 0, 32'h0102_0304);
        send_term(3, 1, 32'h0506_0708);
        send_end();

        // store full, and the receiver holds off during the emission
        set_shape(128, 128);
        hold_armed <= 1'b1;
        for (int k = 0; k < MAX_NONZERO_DEF + 2; k++)
            send_term($urandom_range(0, 127), $urandom_range(0, 127), pick_value());
        send_end();

        // first random matrix keeps offering input while the long hold runs
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            if (items_sent != random_base && $urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       cols = 1;
                    1:       cols = 2;
                    2:       cols = 128;
                    3:       cols = 200;
                    default: cols = $urandom_range(1, 128);
                endcase
                set_shape(($urandom_range(0, 5) == 0) ? 255 : $urandom_range(1, 128), cols);
            end
            n_terms = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68)
                                                  : $urandom_range(0, 10);
            if (n_terms > RANDOM_ITEMS - 1 - (items_sent - random_base))
                n_terms = RANDOM_ITEMS - 1 - (items_sent - random_base);
            for (int k = 0; k < n_terms; k++)
                send_term($urandom_range(0, 127), pick_column(), pick_value());
            send_end();
        end

        drain_to_idle();
        $display("Run covered %0d matrices over %0d input transfers, %0d results checked.",
                 matrices_ended, items_sent, results_checked);
        $display("%0d terms refused, %0d register writes, long output hold done: %0d.",
                 refused_terms, reg_writes, long_hold_done);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
